@@ sv/scp_pkg.sv @@
`default_nettype none

package scp_pkg;

	// Default field widths.
	localparam int ANGLE_WIDTH_DEF  = 32;
	localparam int RESULT_WIDTH_DEF = 32;

	// Pipeline depth, from the input register to the output register.
	localparam int NUM_STAGES = 10;

	// Angle magnitude in unsigned Q.32 is below 2^39 plus one, so 40 bits hold it.
	localparam int A32_W = 40;
	// Quadrant count width; the count itself stays below 128.
	localparam int Q_W   = 8;
	// Width of the reduced angle in signed Q.32.
	localparam int RED_W = 42;

	// 2/pi in Q0.32, truncated.
	localparam logic [31:0] QUAD_SCALE_Q32 = 32'hA2F9_836E;
	// pi/2 in Q.32 as the sum of 201/128 and its remainder.
	localparam logic [32:0] HALF_PI_Q32 = 33'((64'd201 << 25) + 64'd2078020);

	// Polynomial coefficients in Q.30.
	localparam logic signed [32:0] POLY_ONE = 33'sd1073741824;
	localparam logic signed [32:0] POLY_C1  = 33'sd178949812;
	localparam logic signed [32:0] POLY_C2  = 33'sd8927412;
	localparam logic signed [32:0] POLY_C3  = 33'sd199093;

	// Largest magnitude of the polynomial argument in Q.30.
	localparam logic signed [31:0] ARG_MAX = 32'sd2147483647;

	typedef logic signed [31:0]      arg_t;
	typedef logic signed [32:0]      coef_t;
	typedef logic signed [33:0]      poly_t;
	typedef logic signed [RED_W-1:0] red_t;

	// Quadrant index, the quadrant count modulo four.
	typedef enum logic [1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} quad_t;

	// Load enables for the polynomial stages.
	typedef struct packed {
		logic s5;
		logic s6;
		logic s7;
		logic s8;
		logic s9;
	} poly_adv_t;

endpackage

`default_nettype wire

@@ sv/scp_poly.sv @@
`default_nettype none

// Odd degree-7 polynomial x*(1 + s*(-C1 + s*(C2 - s*C3))), s = x^2, in Q.30.
// One multiplier per stage, five stages.
module scp_poly (
	input  wire logic               clk,
	input  wire scp_pkg::poly_adv_t adv,
	input  wire scp_pkg::arg_t      x,
	output scp_pkg::poly_t          y
);
	import scp_pkg::*;

	arg_t  x_s5, x_s6, x_s7, x_s8;
	coef_t s_s5, s_s6, s_s7;
	coef_t t_s6, t_s7, t_s8;
	poly_t y_s9;

	logic signed [63:0] sq;
	logic signed [65:0] p6, p7, p8, p9;

	// Products of each stage, all floored back to Q.30 when registered.
	assign sq = x * x;
	assign p6 = s_s5 * POLY_C3;
	assign p7 = s_s6 * t_s6;
	assign p8 = s_s7 * t_s7;
	assign p9 = x_s8 * t_s8;

	// Square of the argument.
	always_ff @(posedge clk) begin
		if (adv.s5) begin
			x_s5 <= x;
			s_s5 <= coef_t'(sq >>> 30);
		end
	end

	// Innermost term: C2 - s*C3.
	always_ff @(posedge clk) begin
		if (adv.s6) begin
			x_s6 <= x_s5;
			s_s6 <= s_s5;
			t_s6 <= coef_t'(66'(POLY_C2) - (p6 >>> 30));
		end
	end

	// Middle term: -C1 + s*t.
	always_ff @(posedge clk) begin
		if (adv.s7) begin
			x_s7 <= x_s6;
			s_s7 <= s_s6;
			t_s7 <= coef_t'((p7 >>> 30) - 66'(POLY_C1));
		end
	end

	// Outer term: 1 + s*t.
	always_ff @(posedge clk) begin
		if (adv.s8) begin
			x_s8 <= x_s7;
			t_s8 <= coef_t'(66'(POLY_ONE) + (p8 >>> 30));
		end
	end

	// Final product with the argument.
	always_ff @(posedge clk) begin
		if (adv.s9) begin
			y_s9 <= poly_t'(p9 >>> 30);
		end
	end

	assign y = y_s9;

endmodule

`default_nettype wire

@@ sv/sin_cos_polynomial_top.sv @@
// Sine and cosine of a fixed-point angle.
//
// Input channel: angle (signed, ANGLE_WIDTH bits, 8 integer bits, radians),
// handshake in_valid / in_ready. Output channel: sine and cosine (signed,
// RESULT_WIDTH bits, 2 integer bits, saturated to plus and minus one),
// handshake out_valid / out_ready. Every item gives exactly one result.
//
// The datapath is a ten-stage pipeline: absolute value, quadrant multiply
// by 2/pi, reduction by pi/2, argument select, five polynomial stages
// (one multiplier each in both polynomials) and the output saturation
// register. One item can be accepted in every cycle unless a stall on the
// output side has filled every stage.
//
// Each stage has its own valid bit and loads whenever it is empty or its
// contents move on, so a stall on the output side fills bubbles first and
// in_ready stays high while any stage is free. Reset empties the pipeline;
// nothing else needs to be initialized.
`default_nettype none

module sin_cos_polynomial_top #(
	parameter int ANGLE_WIDTH  = scp_pkg::ANGLE_WIDTH_DEF,
	parameter int RESULT_WIDTH = scp_pkg::RESULT_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic signed [ANGLE_WIDTH-1:0]  angle,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [RESULT_WIDTH-1:0]      sine,
	output logic signed [RESULT_WIDTH-1:0]      cosine
);
	import scp_pkg::*;

	localparam logic signed [RESULT_WIDTH-1:0] ONE_RES =
		RESULT_WIDTH'(1) << (RESULT_WIDTH - 2);

	// Floor to Q.30 and clamp to the polynomial's argument range.
	function automatic arg_t clamp_arg(input red_t v);
		red_t sh;
		sh = v >>> 2;
		if (sh > RED_W'(ARG_MAX)) begin
			return ARG_MAX;
		end else if (sh < -RED_W'(ARG_MAX)) begin
			return -ARG_MAX;
		end
		return arg_t'(sh);
	endfunction

	// Clamp a polynomial result to plus or minus one in Q.30.
	function automatic logic signed [31:0] clamp_res(input poly_t v);
		if (v > 34'(POLY_ONE)) begin
			return 32'(POLY_ONE);
		end else if (v < -34'(POLY_ONE)) begin
			return -32'(POLY_ONE);
		end
		return 32'(v);
	endfunction

	logic [NUM_STAGES:1] vld_q;
	logic [NUM_STAGES:1] adv;

	logic [A32_W-1:0] a32_s1, a32_s2;
	logic [Q_W-1:0]   q_s2;
	red_t             r_s3, rm_s3;
	quad_t            quad_s3;
	arg_t             xs_s4, xc_s4;
	logic             neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic             neg_s6, neg_s7, neg_s8, neg_s9;
	logic signed [RESULT_WIDTH-1:0] sine_s10, cosine_s10;

	// Stage enables: a stage loads when it is empty or its item moves on.
	always_comb begin
		adv[NUM_STAGES] = !vld_q[NUM_STAGES] || out_ready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign in_ready  = adv[1];
	assign out_valid = vld_q[NUM_STAGES];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: magnitude of the angle, aligned to unsigned Q.32.
	logic [ANGLE_WIDTH-1:0] ang_u;
	logic [ANGLE_WIDTH-1:0] mag;
	logic [A32_W-1:0]       a32_in;

	assign ang_u = angle;
	assign mag   = angle[ANGLE_WIDTH-1] ? ANGLE_WIDTH'(~ang_u + 1'b1) : ang_u;

	generate
		if (ANGLE_WIDTH < A32_W) begin : g_align_up
			assign a32_in = {mag, {(A32_W - ANGLE_WIDTH){1'b0}}};
		end else begin : g_align_down
			assign a32_in = mag[ANGLE_WIDTH-1 -: A32_W];
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			a32_s1 <= a32_in;
			neg_s1 <= angle[ANGLE_WIDTH-1];
		end
	end

	// Stage 2: quadrant count, floor(|a| * 2/pi).
	logic [63:0] q_prod;

	assign q_prod = a32_s1[A32_W-1:8] * QUAD_SCALE_Q32;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			q_s2   <= q_prod[63:56];
			a32_s2 <= a32_s1;
			neg_s2 <= neg_s1;
		end
	end

	// Stage 3: reduce by q * pi/2, and form the distance to the next quadrant.
	logic [RED_W-1:0] qhp;
	red_t             r_in;

	assign qhp  = RED_W'(q_s2) * RED_W'(HALF_PI_Q32);
	assign r_in = $signed(RED_W'(a32_s2)) - $signed(qhp);

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			r_s3    <= r_in;
			rm_s3   <= r_in - $signed(RED_W'(HALF_PI_Q32));
			quad_s3 <= quad_t'(q_s2[1:0]);
			neg_s3  <= neg_s2;
		end
	end

	// Stage 4: pick the polynomial arguments by quadrant.
	red_t xs_sel, xc_sel;

	always_comb begin
		case (quad_s3)
			QUAD_I: begin
				xs_sel = r_s3;
				xc_sel = -rm_s3;
			end
			QUAD_II: begin
				xs_sel = -rm_s3;
				xc_sel = -r_s3;
			end
			QUAD_III: begin
				xs_sel = -r_s3;
				xc_sel = rm_s3;
			end
			QUAD_IV: begin
				xs_sel = rm_s3;
				xc_sel = r_s3;
			end
			default: begin
				xs_sel = r_s3;
				xc_sel = r_s3;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			xs_s4  <= clamp_arg(xs_sel);
			xc_s4  <= clamp_arg(xc_sel);
			neg_s4 <= neg_s3;
		end
	end

	// Stages 5 to 9: the two polynomials.
	poly_adv_t poly_adv;
	poly_t     ys, yc;

	assign poly_adv = '{s5: adv[5], s6: adv[6], s7: adv[7], s8: adv[8], s9: adv[9]};

	scp_poly u_poly_sin (
		.clk (clk),
		.adv (poly_adv),
		.x   (xs_s4),
		.y   (ys)
	);

	scp_poly u_poly_cos (
		.clk (clk),
		.adv (poly_adv),
		.x   (xc_s4),
		.y   (yc)
	);

	// The sign flag follows the item through the polynomial stages.
	always_ff @(posedge clk) begin
		if (adv[5]) neg_s5 <= neg_s4;
		if (adv[6]) neg_s6 <= neg_s5;
		if (adv[7]) neg_s7 <= neg_s6;
		if (adv[8]) neg_s8 <= neg_s7;
		if (adv[9]) neg_s9 <= neg_s8;
	end

	// Stage 10: sign of sine, saturation and scaling to the result format.
	logic signed [31:0]             sn_c, cs_c;
	logic signed [RESULT_WIDTH-1:0] sn_res, cs_res;

	assign sn_c = clamp_res(neg_s9 ? -ys : ys);
	assign cs_c = clamp_res(yc);

	generate
		if (RESULT_WIDTH <= 32) begin : g_res_narrow
			assign sn_res = sn_c[31 -: RESULT_WIDTH];
			assign cs_res = cs_c[31 -: RESULT_WIDTH];
		end else begin : g_res_wide
			assign sn_res = {sn_c, {(RESULT_WIDTH - 32){1'b0}}};
			assign cs_res = {cs_c, {(RESULT_WIDTH - 32){1'b0}}};
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			sine_s10   <= sn_res;
			cosine_s10 <= cs_res;
		end
	end

	assign sine   = sine_s10;
	assign cosine = cosine_s10;

	// The quadrant count of any angle in range stays below 128.
	a_q_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[2] |-> !q_s2[Q_W-1])
		else $error("quadrant count out of range");

	// Both polynomial arguments are clamped symmetrically.
	a_arg_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[4] |-> (xs_s4 >= -ARG_MAX) && (xc_s4 >= -ARG_MAX))
		else $error("polynomial argument outside clamp range");

	// Results never exceed plus or minus one.
	a_out_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sine <= ONE_RES) && (sine >= -ONE_RES) &&
			(cosine <= ONE_RES) && (cosine >= -ONE_RES))
		else $error("result outside plus or minus one");

	// With the output register free, the pipeline must take a new item.
	a_ready_tail_free: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[NUM_STAGES] |-> in_ready)
		else $error("input stalled with output register empty");

	// An accepted item always lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[1])
		else $error("accepted item lost at pipeline entry");

endmodule

`default_nettype wire

@@ tb/sin_cos_polynomial_checker.sv @@
`timescale 1ns / 1ps

module sin_cos_polynomial_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] angle,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] sine,
	input  logic signed [31:0] cosine,
	output int                 mismatch_count,
	output int                 results_due
);

	import scp_pkg::*;

	// Two-part pi/2 in Q.32, 2/pi in Q0.32 and the series coefficients in Q.30.
	localparam longint HALF_PI_HI  = 64'sd201 << 25;
	localparam longint HALF_PI_LO  = 64'sd2078020;
	localparam longint QUAD_SCALE  = 64'sh0000_0000_A2F9_836E;
	localparam longint UNIT_Q30    = 64'sd1 << 30;
	localparam longint COEF_C1     = 64'sd178949812;
	localparam longint COEF_C2     = 64'sd8927412;
	localparam longint COEF_C3     = 64'sd199093;
	localparam longint ARG_CLAMP   = 64'sd2147483647;

	typedef struct packed {
		logic signed [31:0] sine;
		logic signed [31:0] cosine;
	} trig_pair_t;

	trig_pair_t trig_expected_q [$];

	// Odd degree-7 series on a signed Q.32 argument; the result is in Q.30.
	// Every right shift rounds toward minus infinity.
	function automatic longint odd_series_q30(longint arg_q32);
		longint x;
		longint x_sq;
		longint acc;
		x = arg_q32 >>> 2;
		if (x > ARG_CLAMP) x = ARG_CLAMP;
		if (x < -ARG_CLAMP) x = -ARG_CLAMP;
		x_sq = (x * x) >>> 30;
		acc  = COEF_C2 - ((x_sq * COEF_C3) >>> 30);
		acc  = -COEF_C1 + ((x_sq * acc) >>> 30);
		acc  = UNIT_Q30 + ((x_sq * acc) >>> 30);
		return (x * acc) >>> 30;
	endfunction

	// Clamp to plus or minus one; the result format is Q2.30, so no rescaling.
	function automatic logic signed [31:0] clamp_unit(longint y);
		if (y > UNIT_Q30) y = UNIT_Q30;
		if (y < -UNIT_Q30) y = -UNIT_Q30;
		return y[31:0];
	endfunction

	// Quadrant reduction of the magnitude, then series on the picked argument.
	function automatic trig_pair_t sincos_of_angle(logic signed [31:0] a);
		longint     signed_a;
		longint     mag;
		longint     mag_q32;
		longint     quad_count;
		longint     rem_lo;
		longint     rem_hi;
		longint     sin_q30;
		longint     cos_q30;
		quad_t      quad;
		trig_pair_t res;
		signed_a   = a;
		mag        = a[31] ? -signed_a : signed_a;
		mag_q32    = mag << 8;
		quad_count = ((mag_q32 >> 8) * QUAD_SCALE) >> 56;
		rem_lo     = mag_q32 - quad_count * HALF_PI_HI - quad_count * HALF_PI_LO;
		rem_hi     = rem_lo - HALF_PI_HI - HALF_PI_LO;
		quad       = quad_t'(quad_count[1:0]);
		case (quad)
			QUAD_I: begin
				sin_q30 = odd_series_q30(rem_lo);
				cos_q30 = odd_series_q30(-rem_hi);
			end
			QUAD_II: begin
				sin_q30 = odd_series_q30(-rem_hi);
				cos_q30 = odd_series_q30(-rem_lo);
			end
			QUAD_III: begin
				sin_q30 = odd_series_q30(-rem_lo);
				cos_q30 = odd_series_q30(rem_hi);
			end
			default: begin
				sin_q30 = odd_series_q30(rem_hi);
				cos_q30 = odd_series_q30(rem_lo);
			end
		endcase
		if (a[31]) sin_q30 = -sin_q30;
		res.sine   = clamp_unit(sin_q30);
		res.cosine = clamp_unit(cos_q30);
		return res;
	endfunction

	// Results are retired before new angles are queued, since a result can
	// never belong to an item taken at the same edge.
	always @(posedge clk) begin
		trig_pair_t exp_pair;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (trig_expected_q.size() == 0) begin
					$error("result with no item outstanding: sine %0d, cosine %0d",
						sine, cosine);
					mismatch_count++;
				end else begin
					exp_pair = trig_expected_q.pop_front();
					if (sine !== exp_pair.sine) begin
						$error("sine: expected %0d, actual %0d", exp_pair.sine, sine);
						mismatch_count++;
					end
					if (cosine !== exp_pair.cosine) begin
						$error("cosine: expected %0d, actual %0d",
							exp_pair.cosine, cosine);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				trig_expected_q.push_back(sincos_of_angle(angle));
			end
			results_due = trig_expected_q.size();
		end
	end

endmodule

@@ tb/sin_cos_polynomial_top_test.sv @@
`timescale 1ns / 1ps

module sin_cos_polynomial_top_test;

	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     LONG_HOLD      = 200;
	localparam int     BUSY_ITEMS     = 600;
	localparam int     LIGHT_ITEMS    = 600;
	localparam int     STEADY_ITEMS   = 230;
	localparam int     NUM_CORNERS    = 19;
	// pi/2 and 2*pi in Q8.24, rounded.
	localparam longint HALF_PI_A      = 64'sd26353589;
	localparam longint FULL_TURN_A    = 64'sd105414357;

	localparam logic signed [31:0] CORNER_ANGLES [NUM_CORNERS] = '{
		32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001,
		32'(HALF_PI_A - 1), 32'(HALF_PI_A), 32'(HALF_PI_A + 1), 32'(-HALF_PI_A),
		32'(2 * HALF_PI_A), 32'(-2 * HALF_PI_A), 32'(3 * HALF_PI_A),
		32'(4 * HALF_PI_A), 32'(5 * HALF_PI_A), 32'sh5555_5555, 32'shAAAA_AAAA,
		32'sh00FF_FFFF, 32'shFF00_0000
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] angle;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] sine;
	logic signed [31:0] cosine;
	int                 mismatch_count;
	int                 results_due;
	int                 tx_idle_odds;
	int                 rx_idle_odds;
	int                 rx_stall_left;
	int                 quiet_cycles;
	bit                 hold_req;

	sin_cos_polynomial_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.angle     (angle),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sine      (sine),
		.cosine    (cosine)
	);

	sin_cos_polynomial_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.angle          (angle),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sine           (sine),
		.cosine         (cosine),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Random angle: full range, within one turn, or just around a multiple
	// of pi/2 where the quadrant count changes.
	function automatic logic signed [31:0] random_angle();
		longint k;
		longint v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				v = $urandom;
			end
			5, 6, 7: begin
				v = $urandom_range(0, 2 * FULL_TURN_A);
				v = v - FULL_TURN_A;
			end
			default: begin
				k = $urandom_range(0, 81);
				v = $urandom_range(0, 128);
				v = v - 64 + k * HALF_PI_A;
				if ($urandom_range(0, 1) == 1) v = -v;
			end
		endcase
		return v[31:0];
	endfunction

	// Offer one item, after a random gap, and return at the falling edge
	// following its acceptance with in_valid still high.
	task automatic offer_angle(input logic signed [31:0] a);
		int gap;
		gap = 0;
		if (tx_idle_odds != 0 && $urandom_range(1, tx_idle_odds) == 1)
			gap = $urandom_range(1, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		angle    <= a;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Stop offering and wait until every outstanding result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (results_due != 0) @(negedge clk);
	endtask

	// Result side: random stall bursts, and one long hold-off on request.
	initial begin
		bit hold_taken;
		hold_taken    = 1'b0;
		out_ready     = 1'b0;
		rx_stall_left = 0;
		wait (arst_n == 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken    = 1'b1;
				rx_stall_left = LONG_HOLD - 1;
				out_ready     <= 1'b0;
			end else if (rx_stall_left > 0) begin
				rx_stall_left--;
				out_ready <= 1'b0;
			end else if (rx_idle_odds != 0 && $urandom_range(1, rx_idle_odds) == 1) begin
				rx_stall_left = $urandom_range(0, 7);
				out_ready     <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		angle        = '0;
		hold_req     = 1'b0;
		tx_idle_odds = 4;
		rx_idle_odds = 4;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Corner angles: range ends, quadrant edges, wrap of the count.
		for (int i = 0; i < NUM_CORNERS; i++) offer_angle(CORNER_ANGLES[i]);
		drain_results();

		// Heavy idling on both sides; midway the result side holds off long
		// enough for the pipeline to fill and push back.
		for (int i = 0; i < BUSY_ITEMS; i++) begin
			if (i == BUSY_ITEMS / 2) hold_req = 1'b1;
			offer_angle(random_angle());
		end
		drain_results();

		// Light idling.
		tx_idle_odds = 12;
		rx_idle_odds = 12;
		for (int i = 0; i < LIGHT_ITEMS; i++) offer_angle(random_angle());

		// Back to back to the end.
		tx_idle_odds = 0;
		rx_idle_odds = 0;
		for (int i = 0; i < STEADY_ITEMS; i++) offer_angle(random_angle());
		drain_results();
		repeat (2 * scp_pkg::NUM_STAGES) @(negedge clk);

		if (mismatch_count == 0 && results_due == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
